[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for the concurrent checks of the question parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define DQP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset
`define DQP_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/dqp_pkg.sv]
// ----------------------------------------------------------------------------
// dqp_pkg
// Types and constants shared by the DNS question parser modules.
// ----------------------------------------------------------------------------
package dqp_pkg;

    // Defaults of the top-level parameters
    localparam int PACKET_BYTES_DEFAULT  = 512;
    localparam int NAME_TEXT_MAX_DEFAULT = 256;

    // Result kinds
    localparam logic [2:0] KIND_CHAR      = 3'd0;
    localparam logic [2:0] KIND_ACCEPTED  = 3'd1;
    localparam logic [2:0] KIND_SKIPPED   = 3'd2;
    localparam logic [2:0] KIND_MALFORMED = 3'd3;
    localparam logic [2:0] KIND_CUT_SHORT = 3'd4;
    localparam logic [2:0] KIND_TOO_SHORT = 3'd5;
    localparam logic [2:0] KIND_RESPONSE  = 3'd6;

    // Header layout (byte offsets)
    localparam int HDR_FLAGS_OFF = 2;
    localparam int HDR_COUNT_OFF = 4;
    localparam int HDR_END_OFF   = 6;
    localparam int HDR_LAST_OFF  = 11;

    localparam logic [15:0] RESPONSE_MASK        = 16'hC000;
    localparam logic [15:0] ACCEPTED_CLASS_RESET = 16'd1;
    localparam logic [7:0]  DOT_CHAR             = 8'd46;
    localparam logic [8:0]  ENC_MAX              = 9'h1FF;

    // Event queue between front and back
    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
    localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

    // One queue entry: up to two results caused by one byte; the second,
    // when present, is always a malformed report
    typedef struct packed {
        logic [2:0]  kind;
        logic        has_second;
        logic [7:0]  name_char;
        logic [6:0]  question_index;
        logic [15:0] query_type;
        logic [15:0] query_class;
        logic [8:0]  raw_name_length;
        logic [15:0] packet_ident;
        logic [3:0]  opcode;
    } evt_t;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  name_char;
        logic [6:0]  question_index;
        logic [15:0] query_type;
        logic [15:0] query_class;
        logic [8:0]  raw_name_length;
        logic [15:0] packet_ident;
        logic [3:0]  opcode;
        logic        last_of_run;
    } res_t;

endpackage

[rtl/dqp_front.sv]
// ----------------------------------------------------------------------------
// dqp_front
// Byte parser: tracks header, labels and type/class, and turns each byte
// into at most one queue entry.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dqp_front #(
    parameter int PACKET_BYTES  = dqp_pkg::PACKET_BYTES_DEFAULT,
    parameter int NAME_TEXT_MAX = dqp_pkg::NAME_TEXT_MAX_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    data_byte,
    input  logic          end_of_packet,
    input  logic          q_full,
    input  logic          cfg_valid,
    input  logic [15:0]   cfg_accepted_class,
    output logic          ev_push,
    output dqp_pkg::evt_t ev
);
    import dqp_pkg::*;

    localparam int OFF_W = $clog2(PACKET_BYTES);
    localparam int TXT_W = $clog2(NAME_TEXT_MAX);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(PACKET_BYTES - 1);
    localparam logic [TXT_W-1:0] TXT_LAST = TXT_W'(NAME_TEXT_MAX - 1);

    localparam logic [1:0] PH_HEADER    = 2'd0;
    localparam logic [1:0] PH_LEN       = 2'd1;
    localparam logic [1:0] PH_LABEL     = 2'd2;
    localparam logic [1:0] PH_TYPECLASS = 2'd3;

    logic [OFF_W-1:0] off_reg,     off_next;
    logic [1:0]       phase_reg,   phase_next;
    logic             stopped_reg, stopped_next;
    logic [1:0]       tc_reg,      tc_next;
    logic [15:0]      acc_reg;
    logic [15:0]      ident_reg,   ident_next;
    logic [15:0]      flags_reg,   flags_next;
    logic [15:0]      total_reg,   total_next;
    logic [6:0]       qnum_reg,    qnum_next;
    logic [7:0]       label_reg,   label_next;
    logic [TXT_W-1:0] text_reg,    text_next;
    logic [8:0]       enc_reg,     enc_next;
    logic [23:0]      tcb_reg,     tcb_next;

    logic        accept;
    logic        last;
    logic        stop;
    logic [8:0]  enc_inc;
    logic [15:0] tc_class;

    assign accept   = push && !q_full;
    assign enc_inc  = (enc_reg != ENC_MAX) ? enc_reg + 9'd1 : enc_reg;
    assign tc_class = {tcb_reg[7:0], data_byte};

    // Parse one byte
    always_comb
    begin
        off_next     = off_reg;
        phase_next   = phase_reg;
        stopped_next = stopped_reg;
        tc_next      = tc_reg;
        ident_next   = ident_reg;
        flags_next   = flags_reg;
        total_next   = total_reg;
        qnum_next    = qnum_reg;
        label_next   = label_reg;
        text_next    = text_reg;
        enc_next     = enc_reg;
        tcb_next     = tcb_reg;
        last         = 1'b0;
        stop         = 1'b0;
        ev_push      = 1'b0;
        ev           = '0;
        ev.question_index = qnum_reg;
        ev.packet_ident   = ident_reg;
        ev.opcode         = flags_reg[14:11];

        if (accept)
        begin
            if (stopped_reg)
            begin
                // Drop bytes until the end mark, then restart
                if (end_of_packet)
                begin
                    off_next     = '0;
                    phase_next   = PH_HEADER;
                    stopped_next = 1'b0;
                end
            end
            else
            begin
                last     = end_of_packet || (off_reg == OFF_LAST);
                off_next = off_reg + OFF_W'(1);

                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (off_reg < OFF_W'(HDR_FLAGS_OFF))
                            ident_next = {ident_reg[7:0], data_byte};
                        else if (off_reg < OFF_W'(HDR_COUNT_OFF))
                            flags_next = {flags_reg[7:0], data_byte};
                        else if (off_reg < OFF_W'(HDR_END_OFF))
                            total_next = {total_reg[7:0], data_byte};

                        if (off_reg >= OFF_W'(HDR_LAST_OFF))
                        begin
                            if ((flags_reg & RESPONSE_MASK) != 16'd0)
                            begin
                                ev_push           = 1'b1;
                                ev.kind           = KIND_RESPONSE;
                                ev.question_index = '0;
                                stop              = 1'b1;
                            end
                            else if (total_reg == 16'd0 || last)
                            begin
                                stop = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_LEN;
                                qnum_next  = '0;
                                text_next  = '0;
                                enc_next   = '0;
                            end
                        end
                        else if (last)
                        begin
                            ev_push           = 1'b1;
                            ev.kind           = KIND_TOO_SHORT;
                            ev.question_index = '0;
                            ev.packet_ident   = '0;
                            ev.opcode         = '0;
                            stop              = 1'b1;
                        end
                    end

                    PH_LEN:
                    begin
                        enc_next = enc_inc;
                        if (last)
                        begin
                            ev_push = 1'b1;
                            ev.kind = KIND_MALFORMED;
                            stop    = 1'b1;
                        end
                        else if (data_byte == 8'd0)
                        begin
                            phase_next = PH_TYPECLASS;
                            tc_next    = '0;
                        end
                        else
                        begin
                            // Separator before every label but the first
                            if (text_reg != '0)
                            begin
                                ev_push = 1'b1;
                                if (text_reg == TXT_LAST)
                                begin
                                    ev.kind = KIND_MALFORMED;
                                    stop    = 1'b1;
                                end
                                else
                                begin
                                    ev.kind      = KIND_CHAR;
                                    ev.name_char = DOT_CHAR;
                                    text_next    = text_reg + TXT_W'(1);
                                end
                            end
                            if (!stop)
                            begin
                                label_next = data_byte;
                                phase_next = PH_LABEL;
                            end
                        end
                    end

                    PH_LABEL:
                    begin
                        enc_next = enc_inc;
                        ev_push  = 1'b1;
                        if (text_reg == TXT_LAST)
                        begin
                            ev.kind = KIND_MALFORMED;
                            stop    = 1'b1;
                        end
                        else
                        begin
                            ev.kind       = KIND_CHAR;
                            ev.name_char  = data_byte;
                            ev.has_second = last;
                            text_next     = text_reg + TXT_W'(1);
                            label_next    = label_reg - 8'd1;
                            if (!last && label_reg == 8'd1)
                                phase_next = PH_LEN;
                        end
                    end

                    PH_TYPECLASS:
                    begin
                        tcb_next = {tcb_reg[15:0], data_byte};
                        tc_next  = tc_reg + 2'd1;
                        if (tc_reg == 2'd3)
                        begin
                            ev_push            = 1'b1;
                            ev.kind            = (tc_class == acc_reg) ? KIND_ACCEPTED
                                                                       : KIND_SKIPPED;
                            ev.query_type      = tcb_reg[23:8];
                            ev.query_class     = tc_class;
                            ev.raw_name_length = enc_reg;
                            if (!last)
                            begin
                                total_next = total_reg - 16'd1;
                                qnum_next  = qnum_reg + 7'd1;
                                if (total_reg == 16'd1)
                                begin
                                    stop = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_LEN;
                                    text_next  = '0;
                                    enc_next   = '0;
                                    tc_next    = '0;
                                end
                            end
                        end
                        else if (last)
                        begin
                            ev_push = 1'b1;
                            ev.kind = KIND_CUT_SHORT;
                            stop    = 1'b1;
                        end
                    end

                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase

                // Hold stopped until the end mark, restart on it
                if (stop || last)
                begin
                    if (end_of_packet)
                    begin
                        off_next     = '0;
                        phase_next   = PH_HEADER;
                        stopped_next = 1'b0;
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg     <= '0;
            phase_reg   <= PH_HEADER;
            stopped_reg <= 1'b0;
            tc_reg      <= '0;
            acc_reg     <= ACCEPTED_CLASS_RESET;
        end
        else
        begin
            off_reg     <= off_next;
            phase_reg   <= phase_next;
            stopped_reg <= stopped_next;
            tc_reg      <= tc_next;
            if (cfg_valid)
                acc_reg <= cfg_accepted_class;
        end
    end

    // Header and name fields
    always_ff @(posedge clk)
    begin
        ident_reg <= ident_next;
        flags_reg <= flags_next;
        total_reg <= total_next;
        qnum_reg  <= qnum_next;
        label_reg <= label_next;
        text_reg  <= text_next;
        enc_reg   <= enc_next;
        tcb_reg   <= tcb_next;
    end

    `DQP_ASSERT(a_body_after_header, (phase_reg != PH_HEADER && !stopped_reg) |-> (off_reg >= OFF_W'(HDR_LAST_OFF + 1)), "question parsing before header end")
    `DQP_ASSERT(a_second_after_char, (ev_push && ev.has_second) |-> (ev.kind == KIND_CHAR), "paired malformed report not behind a name char")

endmodule

[rtl/dqp_evq.sv]
// ----------------------------------------------------------------------------
// dqp_evq
// Short event queue that decouples the parser from the result side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dqp_evq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dqp_pkg::evt_t push_data,
    input  logic          pop,
    output dqp_pkg::evt_t pop_data,
    output logic          full,
    output logic          empty
);
    import dqp_pkg::*;

    evt_t                 mem [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [EVQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [EVQ_CNT_W-1:0] count_reg,  count_next;

    assign full     = (count_reg == EVQ_CNT_W'(EVQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + EVQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + EVQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + EVQ_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - EVQ_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item at the tail
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    `DQP_NEVER(a_no_overflow, push && full, "event queue written while full")
    `DQP_NEVER(a_no_underflow, pop && empty, "event queue read while empty")

endmodule

[rtl/dqp_back.sv]
// ----------------------------------------------------------------------------
// dqp_back
// Result stage: unpacks each queue entry into one or two result items and
// holds the oldest one on the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dqp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  dqp_pkg::evt_t q_data,
    input  logic          q_empty,
    output logic          q_pop,
    input  logic          pop,
    output logic          empty,
    output dqp_pkg::res_t res
);
    import dqp_pkg::*;

    evt_t ev_reg;
    logic valid_reg,  valid_next;
    logic second_reg, second_next;
    logic taken;
    logic last_now;
    logic fetch;

    assign last_now = second_reg || !ev_reg.has_second;
    assign taken    = pop && valid_reg;
    assign fetch    = !valid_reg || (taken && last_now);
    assign q_pop    = fetch && !q_empty;
    assign empty    = !valid_reg;

    // Present the first result, or the malformed report that follows it
    always_comb
    begin
        res                 = '0;
        res.question_index  = ev_reg.question_index;
        res.packet_ident    = ev_reg.packet_ident;
        res.opcode          = ev_reg.opcode;
        res.last_of_run     = last_now;
        if (second_reg)
        begin
            res.kind = KIND_MALFORMED;
        end
        else
        begin
            res.kind            = ev_reg.kind;
            res.name_char       = ev_reg.name_char;
            res.query_type      = ev_reg.query_type;
            res.query_class     = ev_reg.query_class;
            res.raw_name_length = ev_reg.raw_name_length;
        end
    end

    // Advance to the second result or the next entry
    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        if (fetch)
        begin
            valid_next  = !q_empty;
            second_next = 1'b0;
        end
        else if (taken)
        begin
            second_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            ev_reg <= q_data;
    end

    `DQP_ASSERT(a_second_has_entry, second_reg |-> (valid_reg && ev_reg.has_second), "second result without a paired entry")
    `DQP_ASSERT(a_second_follows, (taken && !last_now) |=> second_reg, "paired malformed report lost")

endmodule

[rtl/dns_question_parser.sv]
// ----------------------------------------------------------------------------
// dns_question_parser
// Takes one packet byte per cycle and reports the question names as text,
// one character per result, then type and class (or an error) per question.
// The input side accepts one byte every cycle while full is low; full rises
// only when the four-entry event queue between the parser and the result
// stage is full, which happens when results are not popped. Each byte adds
// at most one queue entry. The result side delivers one item per cycle
// while pop is high and one is waiting; a byte that ends the packet inside
// a label gives two items: the character, then the malformed report. A
// result passes the event queue and the result register before it shows.
// The class register is written through cfg_valid/cfg_ready, always ready.
// ----------------------------------------------------------------------------
module dns_question_parser #(
    parameter int PACKET_BYTES  = dqp_pkg::PACKET_BYTES_DEFAULT,
    parameter int NAME_TEXT_MAX = dqp_pkg::NAME_TEXT_MAX_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_accepted_class,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_packet,
    input  logic        pop,
    output logic        empty,
    output logic [2:0]  kind,
    output logic [7:0]  name_char,
    output logic [6:0]  question_index,
    output logic [15:0] query_type,
    output logic [15:0] query_class,
    output logic [8:0]  raw_name_length,
    output logic [15:0] packet_ident,
    output logic [3:0]  opcode,
    output logic        last_of_run
);
    import dqp_pkg::*;

    evt_t front_ev;
    evt_t q_data;
    res_t res;
    logic front_push;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    // Parse bytes
    dqp_front #(
        .PACKET_BYTES  (PACKET_BYTES),
        .NAME_TEXT_MAX (NAME_TEXT_MAX)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .data_byte          (data_byte),
        .end_of_packet      (end_of_packet),
        .q_full             (q_full),
        .cfg_valid          (cfg_valid),
        .cfg_accepted_class (cfg_accepted_class),
        .ev_push            (front_push),
        .ev                 (front_ev)
    );

    // Buffer events
    dqp_evq u_evq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_ev),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Deliver results
    dqp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign kind            = res.kind;
    assign name_char       = res.name_char;
    assign question_index  = res.question_index;
    assign query_type      = res.query_type;
    assign query_class     = res.query_class;
    assign raw_name_length = res.raw_name_length;
    assign packet_ident    = res.packet_ident;
    assign opcode          = res.opcode;
    assign last_of_run     = res.last_of_run;

endmodule
